// ----- hdl/dlstq_pkg.sv -----
package dlstq_pkg;

	localparam int MAX_SLEEPERS_DEF = 16;
	// At most this many threads wake on one tick.
	localparam int MAX_WAKES = 16;

	localparam logic [9:0]  TICK_MS_RESET      = 10'd10;
	localparam logic [15:0] TIMESLICE_MS_RESET = 16'd50;

	localparam logic [1:0] FUNC_SLEEP  = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	localparam logic [1:0] CFG_TICK_MS      = 2'd0;
	localparam logic [1:0] CFG_TIMESLICE_MS = 2'd1;

	localparam logic KIND_WOKEN = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] thread_id;
		logic [31:0] sleep_ms;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] woken_id;
		logic        status;
		logic        reschedule;
		logic [31:0] elapsed_ms;
		logic [31:0] tick_total;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] thread;
		logic [31:0] delta;
	} entry_t;

endpackage

// ----- hdl/dlstq_ram.sv -----
module dlstq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/delta_list_sleep_timer_queue.sv -----
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      in_data  (req_t: func, thread_id, sleep_ms)
// out       output     out_valid / out_ready    out_data (rsp_t: kind .. last)
// cfg       input      cfg_valid / cfg_ready    cfg_index, cfg_data (always ready)
//
// One request at a time; the list sits in a RAM with a registered read, so each list step is
// a read state followed by a state that uses the data. The request port reopens as the final
// result appears.
// Reset clears the count and time counters and resets the config; the RAM needs no clearing.
// A full output register holds the sequencer until the downstream side takes the result.
module delta_list_sleep_timer_queue
	import dlstq_pkg::*;
#(
	parameter int MAX_SLEEPERS = MAX_SLEEPERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IW = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
	localparam int CW = $clog2(MAX_SLEEPERS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_SLEEPERS);
	localparam logic [CW-1:0] ONE  = CW'(1);

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_S_RD  = 15'b000000000000010,
		ST_S_CMP = 15'b000000000000100,
		ST_SH_RD = 15'b000000000001000,
		ST_SH_WR = 15'b000000000010000,
		ST_S_SUC = 15'b000000000100000,
		ST_S_NEW = 15'b000000001000000,
		ST_R_RD  = 15'b000000010000000,
		ST_R_CMP = 15'b000000100000000,
		ST_L_RD  = 15'b000001000000000,
		ST_L_WR  = 15'b000010000000000,
		ST_T_RD  = 15'b000100000000000,
		ST_T_CMP = 15'b001000000000000,
		ST_T_OUT = 15'b010000000000000,
		ST_FIN   = 15'b100000000000000
	} state_t;

	state_t state_q;

	// Configuration and architectural state.
	logic [9:0]    tick_ms_q;
	logic [15:0]   timeslice_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   elapsed_q;
	logic [31:0]   last_resched_q;
	logic [31:0]   ticks_q;

	// Working registers of the sequencer.
	req_t          req_q;
	logic [CW-1:0] idx_q;   // scan position or destination of a left copy
	logic [CW-1:0] j_q;     // destination of a right copy
	logic [CW-1:0] off_q;   // source offset of a left copy
	logic [CW-1:0] lim_q;   // left copies run while idx_q is below this
	logic [CW-1:0] k_q;     // threads woken so far on this tick
	logic [32:0]   acc_q;
	logic [31:0]   inc_q;
	logic [31:0]   add_q;   // added to the first copied delta
	entry_t        hold_q;
	logic          status_q;

	rsp_t out_q;
	logic out_valid_q;
	logic slot_free;
	logic emit;

	// RAM port signals.
	logic          we;
	logic [IW-1:0] waddr;
	entry_t        wdata;
	logic [IW-1:0] raddr;
	entry_t        rdata;
	logic [31:0]   dnew;
	logic [CW-1:0] src;
	logic [CW-1:0] j_dec;
	logic [CW-1:0] idx_inc;

	dlstq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_SLEEPERS),
		.AW(IW)
	) u_list (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || out_ready;
	// A result is loaded into the output register in this cycle.
	assign emit = slot_free && ((state_q == ST_T_OUT) || (state_q == ST_FIN));

	// Delay of a new sleeper relative to its predecessor.
	assign dnew    = req_q.sleep_ms - acc_q[31:0];
	assign src     = idx_q + off_q;
	assign j_dec   = j_q - ONE;
	assign idx_inc = idx_q + ONE;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = rdata;
		raddr = idx_q[IW-1:0];
		unique case (state_q)
			ST_S_RD: begin
				if (idx_q == cnt_q) begin
					// Goes to the tail: no successor to adjust.
					we    = 1'b1;
					waddr = cnt_q[IW-1:0];
					wdata = '{thread: req_q.thread_id, delta: dnew};
				end
			end
			ST_SH_RD: raddr = j_dec[IW-1:0];
			ST_SH_WR: begin
				we    = 1'b1;
				waddr = j_q[IW-1:0];
				wdata = rdata;
			end
			ST_S_SUC: begin
				we    = 1'b1;
				waddr = idx_inc[IW-1:0];
				wdata = '{thread: hold_q.thread, delta: hold_q.delta - dnew};
			end
			ST_S_NEW: begin
				we    = 1'b1;
				waddr = idx_q[IW-1:0];
				wdata = '{thread: req_q.thread_id, delta: dnew};
			end
			ST_L_RD: raddr = src[IW-1:0];
			ST_L_WR: begin
				we    = 1'b1;
				waddr = idx_q[IW-1:0];
				wdata = '{thread: rdata.thread, delta: rdata.delta + add_q};
			end
			ST_T_RD: raddr = k_q[IW-1:0];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tick_ms_q      <= TICK_MS_RESET;
			timeslice_q    <= TIMESLICE_MS_RESET;
			cnt_q          <= '0;
			elapsed_q      <= '0;
			last_resched_q <= '0;
			ticks_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_TICK_MS:      tick_ms_q   <= cfg_data[9:0];
					CFG_TIMESLICE_MS: timeslice_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// The register stays full until taken; a new result is loaded only when it is empty or being taken.
			out_valid_q <= emit || (out_valid_q && !out_ready);

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q    <= in_data;
						idx_q    <= '0;
						acc_q    <= '0;
						k_q      <= '0;
						status_q <= 1'b0;
						inc_q    <= {22'd0, tick_ms_q};
						unique case (in_data.func)
							FUNC_SLEEP: begin
								if (cnt_q == FULL) begin
									status_q <= 1'b1;
									state_q  <= ST_FIN;
								end else begin
									state_q <= ST_S_RD;
								end
							end
							FUNC_REMOVE: state_q <= ST_R_RD;
							FUNC_TICK: begin
								ticks_q   <= ticks_q + 32'd1;
								elapsed_q <= elapsed_q + {22'd0, tick_ms_q};
								state_q   <= ST_T_RD;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end

				// Sleep: walk while the running sum stays at or below the wake time.
				ST_S_RD: begin
					if (idx_q == cnt_q) begin
						cnt_q   <= cnt_q + ONE;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_S_CMP;
					end
				end
				ST_S_CMP: begin
					if (acc_q + {1'b0, rdata.delta} <= {1'b0, req_q.sleep_ms}) begin
						acc_q   <= acc_q + {1'b0, rdata.delta};
						idx_q   <= idx_q + ONE;
						state_q <= ST_S_RD;
					end else begin
						hold_q  <= rdata;
						j_q     <= cnt_q;
						state_q <= ST_SH_RD;
					end
				end
				ST_SH_RD: begin
					if (j_q > idx_inc) begin
						state_q <= ST_SH_WR;
					end else begin
						state_q <= ST_S_SUC;
					end
				end
				ST_SH_WR: begin
					j_q     <= j_q - ONE;
					state_q <= ST_SH_RD;
				end
				ST_S_SUC: state_q <= ST_S_NEW;
				ST_S_NEW: begin
					cnt_q   <= cnt_q + ONE;
					state_q <= ST_FIN;
				end

				// Remove: find the first match, then close the gap.
				ST_R_RD: begin
					if (idx_q == cnt_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_R_CMP;
					end
				end
				ST_R_CMP: begin
					if (rdata.thread == req_q.thread_id) begin
						add_q   <= rdata.delta;
						off_q   <= ONE;
						lim_q   <= cnt_q - ONE;
						cnt_q   <= cnt_q - ONE;
						state_q <= ST_L_RD;
					end else begin
						idx_q   <= idx_q + ONE;
						state_q <= ST_R_RD;
					end
				end

				// Left copy shared by remove and tick compaction.
				ST_L_RD: begin
					if (idx_q < lim_q) begin
						state_q <= ST_L_WR;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_L_WR: begin
					add_q   <= '0;
					idx_q   <= idx_q + ONE;
					state_q <= ST_L_RD;
				end

				// Tick: heads at index k_q wake until one is not due, the list is empty or MAX_WAKES have woken.
				ST_T_RD: begin
					if (cnt_q == '0) begin
						idx_q   <= '0;
						off_q   <= k_q;
						lim_q   <= '0;
						add_q   <= '0;
						state_q <= ST_L_RD;
					end else begin
						state_q <= ST_T_CMP;
					end
				end
				ST_T_CMP: begin
					idx_q <= '0;
					off_q <= k_q;
					if (rdata.delta > inc_q) begin
						add_q   <= 32'd0 - inc_q;
						lim_q   <= cnt_q;
						state_q <= ST_L_RD;
					end else if (32'(k_q) == 32'(MAX_WAKES)) begin
						add_q   <= '0;
						lim_q   <= cnt_q;
						state_q <= ST_L_RD;
					end else begin
						inc_q   <= inc_q - rdata.delta;
						hold_q  <= rdata;
						state_q <= ST_T_OUT;
					end
				end
				ST_T_OUT: begin
					if (slot_free) begin
						out_q <= '{kind: KIND_WOKEN, woken_id: hold_q.thread, status: 1'b0,
							reschedule: 1'b0, elapsed_ms: elapsed_q, tick_total: ticks_q,
							last: 1'b0};
						k_q     <= k_q + ONE;
						cnt_q   <= cnt_q - ONE;
						state_q <= ST_T_RD;
					end
				end

				ST_FIN: begin
					if (slot_free) begin
						logic resched;
						resched = (req_q.func == FUNC_TICK) && ((k_q != '0) ||
							(elapsed_q - last_resched_q >= {16'd0, timeslice_q}));
						if (resched) begin
							last_resched_q <= elapsed_q;
						end
						out_q <= '{kind: KIND_FINAL, woken_id: 16'd0, status: status_q,
							reschedule: resched, elapsed_ms: elapsed_q, tick_total: ticks_q,
							last: 1'b1};
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
